// ===== rtl/thc_pkg.sv =====
// Shared constants, tables and register codes for the tilt-compensated heading block.
package thc_pkg;

  // Field and angle formats
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int FIELD_WIDTH     = 16;
  localparam int CORDIC_STAGES   = 16;

  localparam int ANG_W  = ANGLE_FRAC_BITS + 3;   // Q3.F angle width
  localparam int CORR_W = FIELD_WIDTH + 1;       // corrected field width
  localparam int ZQ     = 28;                    // internal angle fraction bits
  localparam int ZSH    = ZQ - ANGLE_FRAC_BITS;  // input/output angle shift
  localparam int ZW     = 32;                    // internal angle width
  localparam int RW     = 33;                    // rotation x/y width (Q30 plus guard)
  localparam int SCW    = 32;                    // sine/cosine width (Q30)
  localparam int PW     = CORR_W + SCW - 1;      // field times sine/cosine
  localparam int TW     = PW + 2;                // atan2 operand width
  localparam int VW     = TW + 2;                // vectoring x/y width

  // Angle constants in Q28, CORDIC gain in Q30
  localparam logic signed [ZW-1:0] PI_Z      = 32'sd843314857;
  localparam logic signed [ZW-1:0] HALF_PI_Z = 32'sd421657428;
  localparam logic signed [ZW-1:0] TWO_PI_Z  = 32'sd1686629713;
  localparam logic signed [RW-1:0] GAIN_Q30  = 33'sd652032874;
  localparam logic signed [ZW-1:0] ROUND_Z   = ZW'(2 ** (ZSH - 1));
  localparam logic signed [ZW-1:0] TWO_PI_OUT =
    ZW'((64'sd1686629713 + 64'sd2 ** (ZSH - 1)) >>> ZSH);

  // atan(2^-i) in Q28
  localparam int TAB_LEN = 24;
  localparam logic signed [ZW-1:0] ATAN_TAB [0:TAB_LEN-1] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
    32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
    32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
    32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
    32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
    32'sd256,       32'sd128,       32'sd64,       32'sd32
  };

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_OFFSET_X,
    REG_OFFSET_Y,
    REG_OFFSET_Z
  } reg_idx_t;

  // Corrected field triple carried down the pipe
  typedef struct packed {
    logic signed [CORR_W-1:0] mx;
    logic signed [CORR_W-1:0] my;
    logic signed [CORR_W-1:0] mz;
  } corr_t;

endpackage

// ===== rtl/thc_in_if.sv =====
// Sample channel: magnetometer field and attitude angles.
interface thc_in_if;
  import thc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [FIELD_WIDTH-1:0] field_x;
  logic signed [FIELD_WIDTH-1:0] field_y;
  logic signed [FIELD_WIDTH-1:0] field_z;
  logic signed [ANG_W-1:0]       roll_angle;
  logic signed [ANG_W-1:0]       pitch_angle;

  modport source (
    output valid, field_x, field_y, field_z, roll_angle, pitch_angle,
    input  ready
  );
  modport sink (
    input  valid, field_x, field_y, field_z, roll_angle, pitch_angle,
    output ready
  );
endinterface

// ===== rtl/thc_out_if.sv =====
// Result channel: heading and offset-corrected field.
interface thc_out_if;
  import thc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic        [ANG_W-1:0]  heading;
  logic signed [CORR_W-1:0] corrected_x;
  logic signed [CORR_W-1:0] corrected_y;
  logic signed [CORR_W-1:0] corrected_z;

  modport source (
    output valid, heading, corrected_x, corrected_y, corrected_z,
    input  ready
  );
  modport sink (
    input  valid, heading, corrected_x, corrected_y, corrected_z,
    output ready
  );
endinterface

// ===== rtl/tilt_compensated_heading_top.sv =====
// Top level: pipelined tilt-compensated compass heading with APB offset registers.
//
// Usage:
//   sample channel (valid/ready) carries field_x/y/z and roll/pitch angles in Q3.13.
//   result channel (valid/ready) returns heading (unsigned Q3.13, 0 to 2 pi) and
//   the field minus the hard-iron offsets, one result per request, in order.
//   APB port holds offset_x (0x0), offset_y (0x4), offset_z (0x8); write only
//   while the pipe is empty. Reads return the sign-extended offset.
// Throughput: one request per cycle while the result is taken or the output register
//   is empty; two rotation CORDICs, the multiply stages and one vectoring CORDIC are
//   each fully pipelined, one stage per iteration.
// Reset: rst (synchronous) empties the pipe and clears the offsets to zero.
// Stall: when the output register holds a result that is not taken, the whole
//   pipe holds and sample.ready drops; nothing is lost or repeated. Empty
//   output register or a taken result lets everything advance.
module tilt_compensated_heading_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [thc_pkg::PADDR_W-1:0]  paddr,
  input  logic [thc_pkg::PDATA_W-1:0]  pwdata,
  output logic [thc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  thc_in_if.sink                       sample,
  thc_out_if.source                    result
);
  import thc_pkg::*;

  localparam int N = CORDIC_STAGES;

  // ---------------- configuration registers ----------------
  logic signed [FIELD_WIDTH-1:0] offset_x, offset_y, offset_z;
  logic                          cfg_wr;
  reg_idx_t                      cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
      offset_z <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_OFFSET_X: offset_x <= pwdata[FIELD_WIDTH-1:0];
        REG_OFFSET_Y: offset_y <= pwdata[FIELD_WIDTH-1:0];
        REG_OFFSET_Z: offset_z <= pwdata[FIELD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_OFFSET_X: prdata = PDATA_W'(offset_x);
      REG_OFFSET_Y: prdata = PDATA_W'(offset_y);
      REG_OFFSET_Z: prdata = PDATA_W'(offset_z);
      default:      prdata = '0;
    endcase
  end

  // ---------------- pipeline advance ----------------
  logic out_valid;
  logic adv;

  assign adv          = !out_valid || result.ready;
  assign sample.ready = adv;

  // ---------------- stage A: offsets and angle range reduction ----------------
  logic signed [ZW-1:0] zr_raw, zp_raw, zr_red, zp_red;
  logic                 fr_n, fp_n;

  always_comb begin
    zr_raw = ZW'(sample.roll_angle) <<< ZSH;
    zp_raw = ZW'(sample.pitch_angle) <<< ZSH;
    zr_red = zr_raw;
    fr_n   = 1'b0;
    if (zr_raw > HALF_PI_Z) begin
      zr_red = zr_raw - PI_Z;
      fr_n   = 1'b1;
    end else if (zr_raw < -HALF_PI_Z) begin
      zr_red = zr_raw + PI_Z;
      fr_n   = 1'b1;
    end
    zp_red = zp_raw;
    fp_n   = 1'b0;
    if (zp_raw > HALF_PI_Z) begin
      zp_red = zp_raw - PI_Z;
      fp_n   = 1'b1;
    end else if (zp_raw < -HALF_PI_Z) begin
      zp_red = zp_raw + PI_Z;
      fp_n   = 1'b1;
    end
  end

  // Rotation CORDIC arrays: roll and pitch side by side
  logic                 rv  [0:N];
  corr_t                rc  [0:N];
  logic                 rfr [0:N];
  logic                 rfp [0:N];
  logic signed [RW-1:0] rxr [0:N];
  logic signed [RW-1:0] ryr [0:N];
  logic signed [ZW-1:0] rzr [0:N];
  logic signed [RW-1:0] rxp [0:N];
  logic signed [RW-1:0] ryp [0:N];
  logic signed [ZW-1:0] rzp [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0] <= 1'b0;
    end else if (adv) begin
      rv[0] <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rc[0].mx <= CORR_W'(sample.field_x) - CORR_W'(offset_x);
      rc[0].my <= CORR_W'(sample.field_y) - CORR_W'(offset_y);
      rc[0].mz <= CORR_W'(sample.field_z) - CORR_W'(offset_z);
      rfr[0]   <= fr_n;
      rfp[0]   <= fp_n;
      rxr[0]   <= GAIN_Q30;
      ryr[0]   <= '0;
      rzr[0]   <= zr_red;
      rxp[0]   <= GAIN_Q30;
      ryp[0]   <= '0;
      rzp[0]   <= zp_red;
    end
  end

  // ---------------- rotation CORDIC stages ----------------
  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (rst) begin
        rv[i+1] <= 1'b0;
      end else if (adv) begin
        rv[i+1] <= rv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rc[i+1]  <= rc[i];
        rfr[i+1] <= rfr[i];
        rfp[i+1] <= rfp[i];
        if (rzr[i] >= 0) begin
          rxr[i+1] <= rxr[i] - (ryr[i] >>> i);
          ryr[i+1] <= ryr[i] + (rxr[i] >>> i);
          rzr[i+1] <= rzr[i] - ATAN_TAB[i];
        end else begin
          rxr[i+1] <= rxr[i] + (ryr[i] >>> i);
          ryr[i+1] <= ryr[i] - (rxr[i] >>> i);
          rzr[i+1] <= rzr[i] + ATAN_TAB[i];
        end
        if (rzp[i] >= 0) begin
          rxp[i+1] <= rxp[i] - (ryp[i] >>> i);
          ryp[i+1] <= ryp[i] + (rxp[i] >>> i);
          rzp[i+1] <= rzp[i] - ATAN_TAB[i];
        end else begin
          rxp[i+1] <= rxp[i] + (ryp[i] >>> i);
          ryp[i+1] <= ryp[i] - (rxp[i] >>> i);
          rzp[i+1] <= rzp[i] + ATAN_TAB[i];
        end
      end
    end
  end

  // ---------------- flip stage: sine and cosine ----------------
  logic signed [RW-1:0]  sr_w, cr_w, sp_w, cp_w;
  logic                  fv;
  corr_t                 fc;
  logic signed [SCW-1:0] sr, cr, sp, cp;

  always_comb begin
    sr_w = rfr[N] ? -ryr[N] : ryr[N];
    cr_w = rfr[N] ? -rxr[N] : rxr[N];
    sp_w = rfp[N] ? -ryp[N] : ryp[N];
    cp_w = rfp[N] ? -rxp[N] : rxp[N];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (adv) begin
      fv <= rv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fc <= rc[N];
      sr <= sr_w[SCW-1:0];
      cr <= cr_w[SCW-1:0];
      sp <= sp_w[SCW-1:0];
      cp <= cp_w[SCW-1:0];
    end
  end

  // ---------------- first multiply stage ----------------
  logic                    m1v;
  corr_t                   m1c;
  logic signed [2*SCW-1:0] spsr_full, spcr_full;
  logic signed [PW-1:0]    p_mycr, p_mzsr, p_mxcp;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1v <= 1'b0;
    end else if (adv) begin
      m1v <= fv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1c       <= fc;
      spsr_full <= sp * sr;
      spcr_full <= sp * cr;
      p_mycr    <= fc.my * cr;
      p_mzsr    <= fc.mz * sr;
      p_mxcp    <= fc.mx * cp;
    end
  end

  // ---------------- second multiply stage ----------------
  logic signed [2*SCW-1:0] spsr_sh, spcr_sh;
  logic signed [SCW-1:0]   spsr, spcr;
  logic                    m2v;
  corr_t                   m2c;
  logic signed [PW-1:0]    p_myspsr, p_mzspcr, m2_mxcp;
  logic signed [TW-1:0]    m2_t1;

  always_comb begin
    spsr_sh = spsr_full >>> 30;
    spcr_sh = spcr_full >>> 30;
    spsr    = spsr_sh[SCW-1:0];
    spcr    = spcr_sh[SCW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m2v <= 1'b0;
    end else if (adv) begin
      m2v <= m1v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2c      <= m1c;
      p_myspsr <= m1c.my * spsr;
      p_mzspcr <= m1c.mz * spcr;
      m2_mxcp  <= p_mxcp;
      m2_t1    <= TW'(p_mycr) + TW'(p_mzsr);
    end
  end

  // ---------------- sum stage: atan2 operands ----------------
  logic                 sv;
  corr_t                sc;
  logic signed [TW-1:0] t1, t2;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= 1'b0;
    end else if (adv) begin
      sv <= m2v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sc <= m2c;
      t1 <= m2_t1;
      t2 <= TW'(m2_mxcp) + TW'(p_myspsr) - TW'(p_mzspcr);
    end
  end

  // ---------------- vectoring pre-rotation ----------------
  logic signed [VW-1:0] ax, ay, px, py;
  logic signed [ZW-1:0] pz;
  logic                 pzero;

  logic                 vv    [0:N];
  corr_t                vc    [0:N];
  logic                 vzero [0:N];
  logic signed [VW-1:0] vx    [0:N];
  logic signed [VW-1:0] vy    [0:N];
  logic signed [ZW-1:0] vz    [0:N];

  always_comb begin
    ax    = VW'(t2);
    ay    = -VW'(t1);
    pzero = (t1 == '0) && (t2 == '0);
    px    = ax;
    py    = ay;
    pz    = '0;
    // left half plane: turn by 90 degrees
    if (ax < 0) begin
      if (ay >= 0) begin
        px = ay;
        py = -ax;
        pz = HALF_PI_Z;
      end else begin
        px = -ay;
        py = ax;
        pz = -HALF_PI_Z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vv[0] <= 1'b0;
    end else if (adv) begin
      vv[0] <= sv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vc[0]    <= sc;
      vzero[0] <= pzero;
      vx[0]    <= px;
      vy[0]    <= py;
      vz[0]    <= pz;
    end
  end

  // ---------------- vectoring CORDIC stages ----------------
  for (genvar j = 0; j < N; j++) begin : g_vec
    always_ff @(posedge clk) begin
      if (rst) begin
        vv[j+1] <= 1'b0;
      end else if (adv) begin
        vv[j+1] <= vv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        vc[j+1]    <= vc[j];
        vzero[j+1] <= vzero[j];
        if (vy[j] >= 0) begin
          vx[j+1] <= vx[j] + (vy[j] >>> j);
          vy[j+1] <= vy[j] - (vx[j] >>> j);
          vz[j+1] <= vz[j] + ATAN_TAB[j];
        end else begin
          vx[j+1] <= vx[j] - (vy[j] >>> j);
          vy[j+1] <= vy[j] + (vx[j] >>> j);
          vz[j+1] <= vz[j] - ATAN_TAB[j];
        end
      end
    end
  end

  // ---------------- wrap, round, output register ----------------
  logic signed [ZW-1:0] zw, hr, hf;
  logic [ANG_W-1:0]     head_n;

  always_comb begin
    zw = (vz[N] < 0) ? vz[N] + TWO_PI_Z : vz[N];
    hr = (zw + ROUND_Z) >>> ZSH;
    hf = (hr >= TWO_PI_OUT) ? hr - TWO_PI_OUT : hr;
    head_n = vzero[N] ? '0 : hf[ANG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.heading     <= head_n;
      result.corrected_x <= vc[N].mx;
      result.corrected_y <= vc[N].my;
      result.corrected_z <= vc[N].mz;
    end
  end

  assign result.valid = out_valid;

`ifndef SYNTHESIS
  // a refused request only ever comes from a held result
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> (result.valid && !result.ready))
    else $error("sample refused without output stall");

  // heading stays below rounded 2 pi
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (ZW'(result.heading) < TWO_PI_OUT))
    else $error("heading out of range");

  // zero horizontal field vector gives zero heading
  a_zero_head: assert property (@(posedge clk) disable iff (rst)
    (vv[N] && vzero[N] && adv) |=> (result.heading == '0))
    else $error("zero vector did not give zero heading");

  // pipe is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");
`endif

endmodule
